FILE: rtl/core/klmc_pkg.sv
package klmc_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int PIDX_W = $clog2(MAX_PATTERN);
	localparam int PREF_W = $clog2(MAX_PATTERN + 1);
	localparam int LEN_W = 7;
	localparam int IDX_W = 6;
	localparam int BYTE_W = 8;
	localparam int CNT_W = 32;

	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [BYTE_W-1:0] UPPER_FIRST = 8'h41;
	localparam logic [BYTE_W-1:0] UPPER_LAST = 8'h5A;
	localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_TEXT = 2'd1;
	localparam logic [1:0] REQ_EOF = 2'd2;

	localparam logic RESULT_LINE = 1'b0;
	localparam logic RESULT_TOTAL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_WRAP,
		ST_LINE_END,
		ST_TOTAL
	} state_t;

	typedef struct packed {
		logic incr;
		logic line_end;
		logic eof_after;
		logic total;
	} res_cmd_t;

	function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = b;
		if (b >= UPPER_FIRST && b <= UPPER_LAST) begin
			c = b + CASE_OFFSET;
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/klmc_ram.sv
module klmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/core/klmc_engine.sv
module klmc_engine
	import klmc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       req_type,
	input  logic [IDX_W-1:0] pattern_index,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [LEN_W-1:0] pattern_length,
	output res_cmd_t         cmd,
	input  logic             res_ready
);

	state_t state_q, state_d;

	logic [BYTE_W-1:0] c_q;
	logic [PIDX_W-1:0] idx_q;
	logic              build_q;
	logic              eof_q;
	logic [PREF_W-1:0] m_q;
	logic [PREF_W-1:0] j_q, j_d;
	logic [PIDX_W-1:0] bp_q;
	logic [PREF_W-1:0] mp_q;
	logic              line_open_q;

	logic              acc;
	logic [BYTE_W-1:0] c_in;
	logic              idx_ok;
	logic [PIDX_W-1:0] idx_in;
	logic [PREF_W-1:0] m_in;
	logic [PREF_W-1:0] j0_build;
	logic [PREF_W-1:0] j0_text;

	logic              pat_we;
	logic [PIDX_W-1:0] pat_ra;
	logic [BYTE_W-1:0] pat_rd;
	logic              fail_we;
	logic [PIDX_W-1:0] fail_wa;
	logic [PIDX_W-1:0] fail_wd;
	logic [PIDX_W-1:0] fail_ra;
	logic [PIDX_W-1:0] fail_rd;

	logic              eq;
	logic              fall;
	logic [PREF_W-1:0] jn;
	logic              wrap_hit;

	assign acc = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign c_in = fold(data_byte);
	assign idx_ok = 32'(pattern_index) < 32'(MAX_PATTERN);
	assign idx_in = PIDX_W'(pattern_index);

	always_comb begin
		if (pattern_length == '0) begin
			m_in = PREF_W'(1);
		end else if (32'(pattern_length) > 32'(MAX_PATTERN)) begin
			m_in = PREF_W'(MAX_PATTERN);
		end else begin
			m_in = PREF_W'(pattern_length);
		end
	end

	assign j0_build = (bp_q >= idx_in) ? '0 : PREF_W'(bp_q);
	assign j0_text = (mp_q >= m_in) ? '0 : mp_q;

	assign eq = (c_q == pat_rd);
	assign fall = !eq && (j_q != '0);
	assign jn = j_q + PREF_W'(eq);
	assign wrap_hit = !build_q && (jn == m_q);

	klmc_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_PATTERN)
	) u_pat_ram (
		.clk    (clk),
		.wr_en  (pat_we),
		.wr_addr(idx_in),
		.wr_data(c_in),
		.rd_addr(pat_ra),
		.rd_data(pat_rd)
	);

	klmc_ram #(
		.WIDTH(PIDX_W),
		.DEPTH(MAX_PATTERN)
	) u_fail_ram (
		.clk    (clk),
		.wr_en  (fail_we),
		.wr_addr(fail_wa),
		.wr_data(fail_wd),
		.rd_addr(fail_ra),
		.rd_data(fail_rd)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (req_type)
						REQ_LOAD: begin
							if (idx_ok && idx_in != '0) begin
								state_d = ST_CMP;
							end
						end
						REQ_TEXT: state_d = ST_CMP;
						REQ_EOF:  state_d = line_open_q ? ST_LINE_END : ST_TOTAL;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_CMP: begin
				if (fall) begin
					state_d = ST_CMP;
				end else if (build_q) begin
					state_d = ST_IDLE;
				end else if (wrap_hit) begin
					state_d = ST_WRAP;
				end else if (c_q == NEWLINE_BYTE) begin
					state_d = ST_LINE_END;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WRAP: state_d = (c_q == NEWLINE_BYTE) ? ST_LINE_END : ST_IDLE;
			ST_LINE_END: begin
				if (res_ready) begin
					state_d = eof_q ? ST_TOTAL : ST_IDLE;
				end
			end
			ST_TOTAL: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pat_we = 1'b0;
		fail_we = 1'b0;
		fail_wa = idx_in;
		fail_wd = '0;
		cmd = '0;
		j_d = j_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (req_type)
						REQ_LOAD: begin
							if (idx_ok) begin
								pat_we = 1'b1;
								if (idx_in == '0) begin
									fail_we = 1'b1;
								end else begin
									j_d = j0_build;
								end
							end
						end
						REQ_TEXT: j_d = j0_text;
						default:  j_d = j_q;
					endcase
				end
			end
			ST_CMP: begin
				if (fall) begin
					j_d = PREF_W'(fail_rd);
				end else if (build_q) begin
					fail_we = 1'b1;
					fail_wa = idx_q;
					fail_wd = PIDX_W'(jn);
				end else if (wrap_hit) begin
					cmd.incr = 1'b1;
				end
			end
			ST_LINE_END: begin
				cmd.line_end = 1'b1;
				cmd.eof_after = eof_q;
			end
			ST_TOTAL: cmd.total = 1'b1;
			default: cmd = '0;
		endcase
		pat_ra = PIDX_W'(j_d);
		if (state_q == ST_CMP && !fall && wrap_hit) begin
			fail_ra = PIDX_W'(m_q - PREF_W'(1));
		end else begin
			fail_ra = PIDX_W'(j_d - PREF_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		j_q <= j_d;
		if (acc) begin
			c_q <= c_in;
			idx_q <= idx_in;
			build_q <= (req_type == REQ_LOAD);
			m_q <= m_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bp_q <= '0;
			mp_q <= '0;
			line_open_q <= 1'b0;
			eof_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						eof_q <= (req_type == REQ_EOF);
						if (req_type == REQ_LOAD && idx_ok && idx_in == '0) begin
							bp_q <= '0;
						end
					end
				end
				ST_CMP: begin
					if (!fall) begin
						if (build_q) begin
							bp_q <= PIDX_W'(jn);
						end else if (!wrap_hit) begin
							mp_q <= jn;
							line_open_q <= 1'b1;
						end
					end
				end
				ST_WRAP: begin
					mp_q <= PREF_W'(fail_rd);
					line_open_q <= 1'b1;
				end
				ST_LINE_END, ST_TOTAL: begin
					if (res_ready) begin
						mp_q <= '0;
						line_open_q <= 1'b0;
					end
				end
				default: line_open_q <= line_open_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/klmc_result.sv
module klmc_result
	import klmc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  res_cmd_t         cmd,
	output logic             res_ready,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             result_kind,
	output logic [CNT_W-1:0] line_number,
	output logic [CNT_W-1:0] match_count,
	output logic             last_result
);

	logic [CNT_W-1:0] lm_q;
	logic [CNT_W-1:0] line_q;
	logic [CNT_W-1:0] total_q;
	logic             out_valid_q;
	logic             kind_q;
	logic [CNT_W-1:0] line_out_q;
	logic [CNT_W-1:0] count_out_q;
	logic             last_q;

	logic             out_free;
	logic             has;
	logic             push_line;
	logic             push_total;
	logic [CNT_W:0]   total_sum;
	logic [CNT_W-1:0] total_sat;

	assign out_free = !out_valid_q || !out_stall;
	assign has = (lm_q != '0);
	assign res_ready = out_free || (!cmd.total && !has);
	assign push_line = cmd.line_end && has && out_free;
	assign push_total = cmd.total && out_free;
	assign total_sum = {1'b0, total_q} + {1'b0, lm_q};
	assign total_sat = total_sum[CNT_W] ? '1 : total_sum[CNT_W-1:0];

	assign out_valid = out_valid_q;
	assign result_kind = kind_q;
	assign line_number = line_out_q;
	assign match_count = count_out_q;
	assign last_result = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lm_q <= '0;
			line_q <= CNT_W'(1);
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.incr && lm_q != '1) begin
				lm_q <= lm_q + CNT_W'(1);
			end
			if (cmd.line_end && res_ready) begin
				if (has) begin
					total_q <= total_sat;
				end
				if (line_q != '1) begin
					line_q <= line_q + CNT_W'(1);
				end
				lm_q <= '0;
			end
			if (push_total) begin
				lm_q <= '0;
				line_q <= CNT_W'(1);
				total_q <= '0;
			end
			if (push_line || push_total) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_line) begin
			kind_q <= RESULT_LINE;
			line_out_q <= line_q;
			count_out_q <= lm_q;
			last_q <= !cmd.eof_after;
		end else if (push_total) begin
			kind_q <= RESULT_TOTAL;
			line_out_q <= '0;
			count_out_q <= total_q;
			last_q <= 1'b1;
		end
	end

endmodule

FILE: rtl/core/kmp_line_match_counter_top.sv
// Case-insensitive KMP line match counter. Pattern bytes are loaded in order
// from index 0 and their failure links are built on the fly; text bytes are
// then matched, counting overlapping hits, with one result per line that holds
// matches and a file total on end of file. The pattern and failure links live
// in two synchronous RAMs. Each comparison reads the RAMs and then compares
// in the compare state; on a mismatch with a nonzero matched prefix the KMP
// fallback takes the failure link and compares again. A text byte that
// completes a match passes through a wrap state to fetch the wrap link, a
// newline passes through a line-end state to close the line, and an end of
// file closes any open line and then reports the total. The block takes no
// new item until it is back in its idle state.
// Results pass through a one-entry output register; closing a line with
// matches or reporting the total waits while that register is held by a stall.
// The pattern length register may be written at any time the block is idle.
module kmp_line_match_counter_top
	import klmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [IDX_W-1:0]  pattern_index,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              result_kind,
	output logic [CNT_W-1:0]  line_number,
	output logic [CNT_W-1:0]  match_count,
	output logic              last_result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LEN_W-1:0]  cfg_data
);

	logic [LEN_W-1:0] len_q;
	res_cmd_t         cmd;
	logic             res_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			len_q <= cfg_data;
		end
	end

	klmc_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.pattern_index (pattern_index),
		.data_byte     (data_byte),
		.pattern_length(len_q),
		.cmd           (cmd),
		.res_ready     (res_ready)
	);

	klmc_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.res_ready  (res_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result_kind(result_kind),
		.line_number(line_number),
		.match_count(match_count),
		.last_result(last_result)
	);

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import klmc_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 300;

	typedef struct packed {
		logic [1:0] req;
		logic [IDX_W-1:0] idx;
		logic [BYTE_W-1:0] data;
	} search_item_t;

	typedef struct packed {
		logic kind;
		logic [CNT_W-1:0] line;
		logic [CNT_W-1:0] count;
		logic last;
	} line_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = REQ_LOAD;
	logic [IDX_W-1:0] pattern_index = '0;
	logic [BYTE_W-1:0] data_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic result_kind;
	logic [CNT_W-1:0] line_number;
	logic [CNT_W-1:0] match_count;
	logic last_result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LEN_W-1:0] cfg_data = '0;

	kmp_line_match_counter_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.pattern_index(pattern_index),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.line_number(line_number),
		.match_count(match_count),
		.last_result(last_result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// expected-behavior copy of the search state
	logic [BYTE_W-1:0] pat_bytes [MAX_PATTERN];
	logic [IDX_W-1:0] fail_links [MAX_PATTERN];
	int build_len;
	int match_len;
	logic [CNT_W-1:0] line_hits;
	logic [CNT_W-1:0] line_no;
	logic [CNT_W-1:0] file_hits;
	logic line_started;
	logic [LEN_W-1:0] pat_len;

	search_item_t pending_items [$];
	line_report_t reports_due [$];
	search_item_t next_item;
	line_report_t want;

	int items_queued = 0;
	int items_taken = 0;
	int mismatches = 0;
	int send_idle = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int loaded_cnt = 0;
	int alpha_n = 2;
	logic [BYTE_W-1:0] letters [3] = '{8'h61, 8'h62, 8'h63};

	function automatic logic [BYTE_W-1:0] lower_ascii(input logic [BYTE_W-1:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
	endfunction

	function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

	task automatic close_line(input logic last_flag);
		line_report_t r;
		if (line_hits != 0) begin
			r.kind = RESULT_LINE;
			r.line = line_no;
			r.count = line_hits;
			r.last = last_flag;
			reports_due.push_back(r);
			file_hits = sat_sum(file_hits, line_hits);
		end
		if (line_no != '1) begin
			line_no = line_no + 1;
		end
		line_hits = '0;
		match_len = 0;
		line_started = 1'b0;
	endtask

	task automatic predict_line_reports(input logic [1:0] req, input logic [IDX_W-1:0] idx,
			input logic [BYTE_W-1:0] raw);
		logic [BYTE_W-1:0] c;
		line_report_t r;
		int j;
		int m;
		c = lower_ascii(raw);
		case (req)
		REQ_LOAD: begin
			pat_bytes[idx] = c;
			if (idx == 0) begin
				fail_links[0] = '0;
				build_len = 0;
			end else begin
				j = build_len;
				if (j >= idx) j = 0;
				while (j > 0 && c != pat_bytes[j]) j = int'(fail_links[j-1]);
				if (c == pat_bytes[j]) j++;
				fail_links[idx] = IDX_W'(j);
				build_len = j;
			end
		end
		REQ_TEXT: begin
			m = int'(pat_len);
			if (m == 0) m = 1;
			if (m > MAX_PATTERN) m = MAX_PATTERN;
			j = match_len;
			if (j >= m) j = 0;
			while (j > 0 && c != pat_bytes[j]) j = int'(fail_links[j-1]);
			if (c == pat_bytes[j]) j++;
			if (j == m) begin
				if (line_hits != '1) line_hits = line_hits + 1;
				j = int'(fail_links[m-1]);
			end
			match_len = j;
			line_started = 1'b1;
			if (c == NEWLINE_BYTE) close_line(1'b1);
		end
		REQ_EOF: begin
			if (line_started) close_line(1'b0);
			r.kind = RESULT_TOTAL;
			r.line = '0;
			r.count = file_hits;
			r.last = 1'b1;
			reports_due.push_back(r);
			line_hits = '0;
			match_len = 0;
			line_no = 1;
			file_hits = '0;
			line_started = 1'b0;
		end
		default: begin
		end
		endcase
	endtask

	task automatic flag_mismatch(input string what, input logic [CNT_W-1:0] got,
			input logic [CNT_W-1:0] exp_val);
		$display("mismatch in %s: got %0h, want %0h", what, got, exp_val);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= REQ_LOAD;
			pattern_index <= '0;
			data_byte <= '0;
			build_len = 0;
			match_len = 0;
			line_hits = '0;
			line_no = 1;
			file_hits = '0;
			line_started = 1'b0;
			pat_len = LEN_W'(1);
		end else begin
			if (in_valid && !in_stall) begin
				predict_line_reports(req_type, pattern_index, data_byte);
				items_taken++;
			end
			if (in_valid && in_stall) begin
				// hold
			end else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
				next_item = pending_items.pop_front();
				in_valid <= 1'b1;
				req_type <= next_item.req;
				pattern_index <= next_item.idx;
				data_byte <= next_item.data;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					flag_mismatch("result with none due", match_count, '0);
				end else begin
					want = reports_due.pop_front();
					if (result_kind !== want.kind)
						flag_mismatch("result_kind", CNT_W'(result_kind), CNT_W'(want.kind));
					if (line_number !== want.line)
						flag_mismatch("line_number", line_number, want.line);
					if (match_count !== want.count)
						flag_mismatch("match_count", match_count, want.count);
					if (last_result !== want.last)
						flag_mismatch("last_result", CNT_W'(last_result), CNT_W'(want.last));
				end
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic queue_item(input logic [1:0] req, input logic [IDX_W-1:0] idx,
			input logic [BYTE_W-1:0] data);
		search_item_t it;
		it.req = req;
		it.idx = idx;
		it.data = data;
		pending_items.push_back(it);
		items_queued++;
	endtask

	function automatic logic [BYTE_W-1:0] letter_any_case();
		return letters[$urandom_range(alpha_n - 1)] ^ ($urandom_range(1) ? 8'h20 : 8'h00);
	endfunction

	function automatic logic [BYTE_W-1:0] pattern_byte();
		int r;
		r = $urandom_range(99);
		if (r < 5) return NEWLINE_BYTE;
		if (r < 10) return BYTE_W'($urandom_range(255));
		return letter_any_case();
	endfunction

	function automatic logic [BYTE_W-1:0] text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 9) return NEWLINE_BYTE;
		if (r < 15) return BYTE_W'($urandom_range(255));
		return letter_any_case();
	endfunction

	task automatic drain_and_settle(input int extra);
		while (items_taken != items_queued || reports_due.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pat_len = v;
	endtask

	initial begin
		int plan_len;
		int n_items;
		int r;
		int top_idx;
		logic [LEN_W-1:0] new_cfg;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		queue_item(REQ_LOAD, 6'd0, "Z");
		queue_item(REQ_TEXT, 6'd0, "z");
		queue_item(REQ_TEXT, 6'h3F, "Z");
		queue_item(REQ_TEXT, 6'd0, NEWLINE_BYTE);
		queue_item(REQ_TEXT, 6'h3F, 8'hFF);
		queue_item(REQ_TEXT, 6'd0, 8'h00);
		queue_item(REQ_TEXT, 6'd0, "@");
		queue_item(REQ_TEXT, 6'd0, "[");
		queue_item(REQ_TEXT, 6'd0, NEWLINE_BYTE);
		queue_item(REQ_EOF, 6'd0, 8'h00);
		queue_item(REQ_EOF, 6'h3F, 8'hFF);
		queue_item(REQ_UNUSED, 6'h3F, 8'hFF);
		queue_item(REQ_TEXT, 6'd0, "z");
		queue_item(REQ_EOF, 6'd0, 8'h00);
		queue_item(REQ_LOAD, 6'd0, NEWLINE_BYTE);
		queue_item(REQ_TEXT, 6'd0, NEWLINE_BYTE);
		queue_item(REQ_TEXT, 6'd0, "a");
		queue_item(REQ_TEXT, 6'd0, NEWLINE_BYTE);
		queue_item(REQ_TEXT, 6'd0, "A");
		queue_item(REQ_EOF, 6'd0, 8'h00);
		loaded_cnt = 1;

		for (int phase = 0; phase < 12; phase++) begin
			drain_and_settle(SETTLE_CYCLES);
			case (phase)
			3: begin
				plan_len = MAX_PATTERN;
				new_cfg = 7'd127;
			end
			4: begin
				plan_len = 0;
				new_cfg = 7'd64;
			end
			7: begin
				plan_len = $urandom_range(1, 6);
				new_cfg = '0;
			end
			default: begin
				plan_len = (phase % 3 == 2) ? 0 : $urandom_range(1, 6);
				new_cfg = LEN_W'((plan_len != 0) ? plan_len :
					$urandom_range(1, (loaded_cnt < 8) ? loaded_cnt : 8));
			end
			endcase
			write_length(new_cfg);

			case (phase % 4)
			0: begin
				send_idle = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle = 69;
				stall_pct = 0;
			end
			2: begin
				send_idle = 0;
				stall_pct = 69;
			end
			default: begin
				send_idle = 20;
				stall_pct = 20;
			end
			endcase

			alpha_n = $urandom_range(2, 3);
			for (int k = 0; k < plan_len; k++) queue_item(REQ_LOAD, IDX_W'(k), pattern_byte());
			if (plan_len > loaded_cnt) loaded_cnt = plan_len;

			n_items = (phase == 3 || phase == 4) ? 80 : 125;
			for (int k = 0; k < n_items; k++) begin
				r = $urandom_range(99);
				if (r < 3) begin
					queue_item(REQ_EOF, IDX_W'($urandom), BYTE_W'($urandom));
				end else if (r < 4) begin
					queue_item(REQ_UNUSED, IDX_W'($urandom), BYTE_W'($urandom));
				end else if (r < 7) begin
					top_idx = (loaded_cnt < MAX_PATTERN - 1) ? loaded_cnt : MAX_PATTERN - 1;
					plan_len = $urandom_range(0, top_idx);
					queue_item(REQ_LOAD, IDX_W'(plan_len), BYTE_W'($urandom));
					if (plan_len + 1 > loaded_cnt) loaded_cnt = plan_len + 1;
				end else begin
					queue_item(REQ_TEXT, IDX_W'($urandom), text_byte());
				end
			end

			if (phase == 8) begin
				@(negedge clk);
				hold_left = 400;
			end
		end

		while (items_taken != items_queued || reports_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/klmc_pkg.sv
rtl/core/klmc_ram.sv
rtl/core/klmc_engine.sv
rtl/core/klmc_result.sv
rtl/core/kmp_line_match_counter_top.sv
test/testbench.sv
